FILE: sv/mxe_pkg.sv
`default_nettype none

package mxe_pkg;

    // Command codes of the instruction class
    typedef enum logic [3:0] {
        CMD_ADC    = 4'd0,
        CMD_SBC    = 4'd1,
        CMD_LD_B   = 4'd2,
        CMD_LD_UB  = 4'd3,
        CMD_LD_H   = 4'd4,
        CMD_LD_UH  = 4'd5,
        CMD_MLT_H  = 4'd6,
        CMD_MLTU_H = 4'd7,
        CMD_MLT_W  = 4'd8,
        CMD_MLTU_W = 4'd9,
        CMD_MAC    = 4'd10
    } t_cmd;

    // Register write-back target
    typedef enum logic [1:0] {
        WT_NONE = 2'd0,
        WT_RD   = 2'd1,
        WT_RS   = 2'd2
    } t_target;

    // Accumulator update selected in the accumulate stage
    typedef enum logic [1:0] {
        ACC_KEEP = 2'd0,
        ACC_LOW  = 2'd1,
        ACC_ALL  = 2'd2,
        ACC_ADD  = 2'd3
    } t_acc_op;

    localparam logic [31:0] PTR_STEP = 32'd2;

    // Captured input item
    typedef struct packed {
        logic [3:0]         cmd;
        logic [31:0]        dest_value;
        logic [31:0]        src_value;
        logic               carry_in;
        logic [31:0]        ptr_first;
        logic [31:0]        ptr_second;
        logic signed [15:0] sample_first;
        logic signed [15:0] sample_second;
    } t_item;

    // Between the operate stage and the accumulate stage
    typedef struct packed {
        logic [31:0] reg_result;
        t_target     write_target;
        logic [31:0] ptr_first_next;
        logic [31:0] ptr_second_next;
        logic        advance_pc;
        logic        flag_n;
        logic        flag_z;
        logic        flag_v;
        logic        flag_c;
        t_acc_op     acc_op;
        logic [63:0] product;
    } t_mid;

    // Finished result item
    typedef struct packed {
        logic [31:0] reg_result;
        t_target     write_target;
        logic [31:0] ptr_first_next;
        logic [31:0] ptr_second_next;
        logic        advance_pc;
        logic        flag_n;
        logic        flag_z;
        logic        flag_v;
        logic        flag_c;
        logic [31:0] acc_high;
        logic [31:0] acc_low;
        logic        mac_overflow;
    } t_res;

endpackage

`default_nettype wire

FILE: sv/mxe_prep.sv
`default_nettype none

// Operate stage: adder, extender and the shared multiplier, registered
module mxe_prep import mxe_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_item i_item,
    output t_mid       o_mid
);

    t_mid r_mid;
    t_mid n_mid;

    logic signed [32:0] w_op_a;
    logic signed [32:0] w_op_b;
    logic signed [63:0] w_prod;
    logic [32:0]        w_sum;
    logic [32:0]        w_sub_rhs;
    logic [32:0]        w_diff;
    logic [31:0]        w_d;
    logic [31:0]        w_s;

    assign w_d = i_item.dest_value;
    assign w_s = i_item.src_value;

    // Multiplier operand selection: all forms fit one 33x33 signed product
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (i_item.cmd)
            CMD_MLT_H: begin
                w_op_a = {{17{w_d[15]}}, w_d[15:0]};
                w_op_b = {{17{w_s[15]}}, w_s[15:0]};
            end
            CMD_MLTU_H: begin
                w_op_a = {17'd0, w_d[15:0]};
                w_op_b = {17'd0, w_s[15:0]};
            end
            CMD_MLT_W: begin
                w_op_a = {w_d[31], w_d};
                w_op_b = {w_s[31], w_s};
            end
            CMD_MLTU_W: begin
                w_op_a = {1'b0, w_d};
                w_op_b = {1'b0, w_s};
            end
            CMD_MAC: begin
                w_op_a = {{17{i_item.sample_first[15]}}, i_item.sample_first};
                w_op_b = {{17{i_item.sample_second[15]}}, i_item.sample_second};
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    // Only the low 64 bits of the product are kept
    assign w_prod = $signed({{31{w_op_a[32]}}, w_op_a}) *
                    $signed({{31{w_op_b[32]}}, w_op_b});

    // Add with carry, subtract with borrow (33 bits, bit 32 is the carry or the borrow)
    assign w_sum     = {1'b0, w_d} + {1'b0, w_s} + {32'd0, i_item.carry_in};
    assign w_sub_rhs = {1'b0, w_s} + {32'd0, i_item.carry_in};
    assign w_diff    = {1'b0, w_d} - w_sub_rhs;

    // Result selection
    always_comb begin
        n_mid                 = '0;
        n_mid.write_target    = WT_NONE;
        n_mid.ptr_first_next  = i_item.ptr_first;
        n_mid.ptr_second_next = i_item.ptr_second;
        n_mid.advance_pc      = 1'b1;
        n_mid.acc_op          = ACC_KEEP;
        n_mid.product         = w_prod;
        case (i_item.cmd)
            CMD_ADC: begin
                n_mid.reg_result   = w_sum[31:0];
                n_mid.write_target = WT_RD;
                n_mid.flag_c       = w_sum[32];
                n_mid.flag_v       = ~(w_d[31] ^ w_s[31]) & (w_d[31] ^ w_sum[31]);
                n_mid.flag_n       = w_sum[31];
                n_mid.flag_z       = (w_sum[31:0] == 32'd0);
            end
            CMD_SBC: begin
                n_mid.reg_result   = w_diff[31:0];
                n_mid.write_target = WT_RD;
                n_mid.flag_c       = w_diff[32];
                n_mid.flag_v       = (w_d[31] ^ w_s[31]) & (w_d[31] ^ w_diff[31]);
                n_mid.flag_n       = w_diff[31];
                n_mid.flag_z       = (w_diff[31:0] == 32'd0);
            end
            CMD_LD_B: begin
                n_mid.reg_result   = {{24{w_s[7]}}, w_s[7:0]};
                n_mid.write_target = WT_RD;
            end
            CMD_LD_UB: begin
                n_mid.reg_result   = {24'd0, w_s[7:0]};
                n_mid.write_target = WT_RD;
            end
            CMD_LD_H: begin
                n_mid.reg_result   = {{16{w_s[15]}}, w_s[15:0]};
                n_mid.write_target = WT_RD;
            end
            CMD_LD_UH: begin
                n_mid.reg_result   = {16'd0, w_s[15:0]};
                n_mid.write_target = WT_RD;
            end
            CMD_MLT_H, CMD_MLTU_H: begin
                n_mid.acc_op = ACC_LOW;
            end
            CMD_MLT_W, CMD_MLTU_W: begin
                n_mid.acc_op = ACC_ALL;
            end
            CMD_MAC: begin
                // zero count: the loop ends and nothing changes
                if (w_s != 32'd0) begin
                    n_mid.acc_op          = ACC_ADD;
                    n_mid.reg_result      = w_s - 32'd1;
                    n_mid.write_target    = WT_RS;
                    n_mid.ptr_first_next  = i_item.ptr_first + PTR_STEP;
                    n_mid.ptr_second_next = i_item.ptr_second + PTR_STEP;
                    n_mid.advance_pc      = 1'b0;
                end
            end
            default: begin
                n_mid.acc_op = ACC_KEEP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid <= n_mid;
        end
    end

    assign o_mid = r_mid;

endmodule

`default_nettype wire

FILE: sv/mxe_accum.sv
`default_nettype none

// Accumulate stage: holds the accumulator and sticky flag, drives the result register
module mxe_accum import mxe_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire t_mid i_mid,
    output t_res      o_res
);

    logic [63:0] r_acc;
    logic [63:0] n_acc;
    logic        r_sticky;
    logic        n_sticky;
    t_res        r_res;
    t_res        n_res;
    logic [63:0] w_acc_sum;
    logic        w_add_ovf;

    // 64-bit accumulate with signed overflow detect
    assign w_acc_sum = r_acc + i_mid.product;
    assign w_add_ovf = (r_acc[63] == i_mid.product[63]) && (w_acc_sum[63] != r_acc[63]);

    always_comb begin
        n_acc    = r_acc;
        n_sticky = r_sticky;
        case (i_mid.acc_op)
            ACC_KEEP: n_acc = r_acc;
            ACC_LOW:  n_acc = {r_acc[63:32], i_mid.product[31:0]};
            ACC_ALL:  n_acc = i_mid.product;
            ACC_ADD: begin
                n_acc    = w_acc_sum;
                n_sticky = r_sticky | w_add_ovf;
            end
            default:  n_acc = r_acc;
        endcase
    end

    // Result item
    always_comb begin
        n_res.reg_result      = i_mid.reg_result;
        n_res.write_target    = i_mid.write_target;
        n_res.ptr_first_next  = i_mid.ptr_first_next;
        n_res.ptr_second_next = i_mid.ptr_second_next;
        n_res.advance_pc      = i_mid.advance_pc;
        n_res.flag_n          = i_mid.flag_n;
        n_res.flag_z          = i_mid.flag_z;
        n_res.flag_v          = i_mid.flag_v;
        n_res.flag_c          = i_mid.flag_c;
        n_res.acc_high        = n_acc[63:32];
        n_res.acc_low         = n_acc[31:0];
        n_res.mac_overflow    = n_sticky;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_sticky <= 1'b0;
        end else if (i_en) begin
            r_acc    <= n_acc;
            r_sticky <= n_sticky;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

FILE: sv/cpu_multiply_extend_execute_core.sv
// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+------------------------------------------
// input   | in        | i_in_valid / o_in_stall | i_cmd, operands, pointers, samples
// output  | out       | o_out_valid / i_out_stall | o_reg_result ... o_mac_overflow
//
// Three register stages: input capture, operate (adder, extender, one 33x33
// multiplier), accumulate. An item is registered in each stage in that order
// before it shows on the outputs; one item per cycle sustained while the
// output is not stalled.
// The accumulator loop closes inside the accumulate stage, so mac steps chain
// back to back. Synchronous active-low reset clears stage valids, accumulator
// and sticky flag. A stall on the output backs up stage by stage; empty stages
// keep accepting.
`default_nettype none

module cpu_multiply_extend_execute_core import mxe_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [3:0]  i_cmd,
    input  wire logic [31:0] i_dest_value,
    input  wire logic [31:0] i_src_value,
    input  wire logic        i_carry_in,
    input  wire logic [31:0] i_ptr_first,
    input  wire logic [31:0] i_ptr_second,
    input  wire logic signed [15:0] i_sample_first,
    input  wire logic signed [15:0] i_sample_second,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_reg_result,
    output logic [1:0]       o_write_target,
    output logic [31:0]      o_ptr_first_next,
    output logic [31:0]      o_ptr_second_next,
    output logic             o_advance_pc,
    output logic             o_flag_n,
    output logic             o_flag_z,
    output logic             o_flag_v,
    output logic             o_flag_c,
    output logic [31:0]      o_acc_high,
    output logic [31:0]      o_acc_low,
    output logic             o_mac_overflow
);

    logic  r_in_valid;
    logic  r_mid_valid;
    logic  r_out_valid;
    t_item r_in;
    t_item n_in;
    t_mid  w_mid;
    t_res  w_res;

    logic w_out_free;
    logic w_mid_free;
    logic w_in_free;
    logic w_mid_move;
    logic w_in_move;
    logic w_accept;

    // Stage flow control: a stage takes new data when empty or draining
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_mid_free = !r_mid_valid || w_out_free;
    assign w_in_free  = !r_in_valid  || w_mid_free;
    assign w_mid_move = r_mid_valid && w_out_free;
    assign w_in_move  = r_in_valid  && w_mid_free;
    assign w_accept   = i_in_valid  && w_in_free;
    assign o_in_stall = !w_in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_free) begin
                r_in_valid <= i_in_valid;
            end
            if (w_mid_free) begin
                r_mid_valid <= r_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_mid_valid;
            end
        end
    end

    // Input capture register
    always_comb begin
        n_in.cmd           = i_cmd;
        n_in.dest_value    = i_dest_value;
        n_in.src_value     = i_src_value;
        n_in.carry_in      = i_carry_in;
        n_in.ptr_first     = i_ptr_first;
        n_in.ptr_second    = i_ptr_second;
        n_in.sample_first  = i_sample_first;
        n_in.sample_second = i_sample_second;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= n_in;
        end
    end

    mxe_prep u_prep (
        .i_clk  (i_clk),
        .i_en   (w_in_move),
        .i_item (r_in),
        .o_mid  (w_mid)
    );

    mxe_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_mid_move),
        .i_mid   (w_mid),
        .o_res   (w_res)
    );

    // Output ports
    assign o_out_valid       = r_out_valid;
    assign o_reg_result      = w_res.reg_result;
    assign o_write_target    = w_res.write_target;
    assign o_ptr_first_next  = w_res.ptr_first_next;
    assign o_ptr_second_next = w_res.ptr_second_next;
    assign o_advance_pc      = w_res.advance_pc;
    assign o_flag_n          = w_res.flag_n;
    assign o_flag_z          = w_res.flag_z;
    assign o_flag_v          = w_res.flag_v;
    assign o_flag_c          = w_res.flag_c;
    assign o_acc_high        = w_res.acc_high;
    assign o_acc_low         = w_res.acc_low;
    assign o_mac_overflow    = w_res.mac_overflow;

endmodule

`default_nettype wire

FILE: sv/mxe_checker.sv
`default_nettype none

// Port-level checks on the execute core
module mxe_checker import mxe_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [31:0] o_reg_result,
    input wire logic [1:0]  o_write_target,
    input wire logic        o_advance_pc,
    input wire logic        o_flag_n,
    input wire logic        o_flag_z,
    input wire logic        o_flag_v,
    input wire logic        o_flag_c,
    input wire logic        o_mac_overflow
);

    // Nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Stalled result holds, including the sticky flag
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_reg_result) && $stable(o_mac_overflow))
        else $error("stalled result changed");

    // No write means a zero result word
    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_write_target == WT_NONE |-> o_reg_result == 32'd0)
        else $error("result word set without a register write");

    // A held PC only comes from a mac step writing the count
    a_mac_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_advance_pc |-> o_write_target == WT_RS)
        else $error("PC held without a count write");

    // Flags only come with an Rd write
    a_flags_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_flag_n || o_flag_z || o_flag_v || o_flag_c)
            |-> o_write_target == WT_RD)
        else $error("flags set outside add or subtract");

endmodule

bind cpu_multiply_extend_execute_core mxe_checker u_mxe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_reg_result   (o_reg_result),
    .o_write_target (o_write_target),
    .o_advance_pc   (o_advance_pc),
    .o_flag_n       (o_flag_n),
    .o_flag_z       (o_flag_z),
    .o_flag_v       (o_flag_v),
    .o_flag_c       (o_flag_c),
    .o_mac_overflow (o_mac_overflow)
);

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import mxe_pkg::*;

    // Spare command codes, decoded as no-operations
    localparam logic [3:0] CMD_SPARE_LO = 4'd11;
    localparam logic [3:0] CMD_SPARE_HI = 4'd15;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [3:0]         i_cmd = '0;
    logic [31:0]        i_dest_value = '0;
    logic [31:0]        i_src_value = '0;
    logic               i_carry_in = 1'b0;
    logic [31:0]        i_ptr_first = '0;
    logic [31:0]        i_ptr_second = '0;
    logic signed [15:0] i_sample_first = '0;
    logic signed [15:0] i_sample_second = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [31:0]        o_reg_result;
    logic [1:0]         o_write_target;
    logic [31:0]        o_ptr_first_next;
    logic [31:0]        o_ptr_second_next;
    logic               o_advance_pc;
    logic               o_flag_n;
    logic               o_flag_z;
    logic               o_flag_v;
    logic               o_flag_c;
    logic [31:0]        o_acc_high;
    logic [31:0]        o_acc_low;
    logic               o_mac_overflow;

    // Predicted architectural state
    logic [63:0] acc_model = '0;
    logic        mac_ovf_model = 1'b0;

    t_res pending_results[$];
    int   fail_count = 0;
    int   items_sent = 0;
    int   send_idle_pct = 0;
    int   out_stall_pct = 0;
    int   hold_cycles = 0;

    cpu_multiply_extend_execute_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_dest_value     (i_dest_value),
        .i_src_value      (i_src_value),
        .i_carry_in       (i_carry_in),
        .i_ptr_first      (i_ptr_first),
        .i_ptr_second     (i_ptr_second),
        .i_sample_first   (i_sample_first),
        .i_sample_second  (i_sample_second),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_reg_result     (o_reg_result),
        .o_write_target   (o_write_target),
        .o_ptr_first_next (o_ptr_first_next),
        .o_ptr_second_next(o_ptr_second_next),
        .o_advance_pc     (o_advance_pc),
        .o_flag_n         (o_flag_n),
        .o_flag_z         (o_flag_z),
        .o_flag_v         (o_flag_v),
        .o_flag_c         (o_flag_c),
        .o_acc_high       (o_acc_high),
        .o_acc_low        (o_acc_low),
        .o_mac_overflow   (o_mac_overflow)
    );

    always #4 i_clk = ~i_clk;

    // Execute one instruction against the predicted state
    function automatic t_res execute_model(input t_item it);
        t_res              r;
        logic [32:0]       wide;
        logic signed [31:0] half_prod;
        logic signed [63:0] word_prod;
        logic [63:0]       addend;
        logic [63:0]       sum;
        r = '0;
        r.write_target = WT_NONE;
        r.ptr_first_next = it.ptr_first;
        r.ptr_second_next = it.ptr_second;
        r.advance_pc = 1'b1;
        case (it.cmd)
            CMD_ADC: begin
                wide = {1'b0, it.dest_value} + {1'b0, it.src_value} + {32'b0, it.carry_in};
                r.reg_result = wide[31:0];
                r.flag_c = wide[32];
                r.flag_v = (it.dest_value[31] == it.src_value[31]) &&
                           (r.reg_result[31] != it.dest_value[31]);
            end
            CMD_SBC: begin
                // borrow when Rd < Rs + C in 33 bits
                wide = {1'b0, it.src_value} + {32'b0, it.carry_in};
                r.reg_result = it.dest_value - it.src_value - {31'b0, it.carry_in};
                r.flag_c = ({1'b0, it.dest_value} < wide);
                r.flag_v = (it.dest_value[31] != it.src_value[31]) &&
                           (r.reg_result[31] != it.dest_value[31]);
            end
            CMD_LD_B: begin
                r.reg_result = {{24{it.src_value[7]}}, it.src_value[7:0]};
                r.write_target = WT_RD;
            end
            CMD_LD_UB: begin
                r.reg_result = {24'b0, it.src_value[7:0]};
                r.write_target = WT_RD;
            end
            CMD_LD_H: begin
                r.reg_result = {{16{it.src_value[15]}}, it.src_value[15:0]};
                r.write_target = WT_RD;
            end
            CMD_LD_UH: begin
                r.reg_result = {16'b0, it.src_value[15:0]};
                r.write_target = WT_RD;
            end
            CMD_MLT_H: begin
                half_prod = $signed({{16{it.dest_value[15]}}, it.dest_value[15:0]}) *
                            $signed({{16{it.src_value[15]}}, it.src_value[15:0]});
                acc_model[31:0] = half_prod;
            end
            CMD_MLTU_H: begin
                acc_model[31:0] = {16'b0, it.dest_value[15:0]} * {16'b0, it.src_value[15:0]};
            end
            CMD_MLT_W: begin
                word_prod = $signed({{32{it.dest_value[31]}}, it.dest_value}) *
                            $signed({{32{it.src_value[31]}}, it.src_value});
                acc_model = word_prod;
            end
            CMD_MLTU_W: begin
                acc_model = {32'b0, it.dest_value} * {32'b0, it.src_value};
            end
            CMD_MAC: begin
                // zero count: loop finished, nothing changes
                if (it.src_value != 32'd0) begin
                    half_prod = $signed({{16{it.sample_first[15]}}, it.sample_first}) *
                                $signed({{16{it.sample_second[15]}}, it.sample_second});
                    addend = {{32{half_prod[31]}}, half_prod};
                    sum = acc_model + addend;
                    if (!mac_ovf_model)
                        mac_ovf_model = (acc_model[63] == addend[63]) &&
                                        (sum[63] != acc_model[63]);
                    acc_model = sum;
                    r.reg_result = it.src_value - 32'd1;
                    r.write_target = WT_RS;
                    r.ptr_first_next = it.ptr_first + PTR_STEP;
                    r.ptr_second_next = it.ptr_second + PTR_STEP;
                    r.advance_pc = 1'b0;
                end
            end
            default: ;
        endcase
        if (it.cmd == CMD_ADC || it.cmd == CMD_SBC) begin
            r.write_target = WT_RD;
            r.flag_n = r.reg_result[31];
            r.flag_z = (r.reg_result == 32'd0);
        end
        r.acc_high = acc_model[63:32];
        r.acc_low = acc_model[31:0];
        r.mac_overflow = mac_ovf_model;
        return r;
    endfunction

    // Operand values biased toward the corners
    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic t_item rand_item(input logic [3:0] cmd);
        t_item it;
        it.cmd = cmd;
        it.dest_value = pick_word();
        it.src_value = pick_word();
        it.carry_in = 1'($urandom_range(1));
        it.ptr_first = pick_word();
        it.ptr_second = pick_word();
        it.sample_first = pick_sample();
        it.sample_second = pick_sample();
        return it;
    endfunction

    function automatic t_item op_item(input logic [3:0] cmd, input logic [31:0] d,
                                      input logic [31:0] s, input logic c);
        t_item it;
        it = rand_item(cmd);
        it.dest_value = d;
        it.src_value = s;
        it.carry_in = c;
        return it;
    endfunction

    function automatic t_item mac_item(input logic [31:0] count, input logic [31:0] p1,
                                       input logic [31:0] p2, input logic [15:0] a,
                                       input logic [15:0] b);
        t_item it;
        it = rand_item(CMD_MAC);
        it.src_value = count;
        it.ptr_first = p1;
        it.ptr_second = p2;
        it.sample_first = a;
        it.sample_second = b;
        return it;
    endfunction

    // One input transfer; the expectation is queued once it is accepted
    task automatic send_item(input t_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= it.cmd;
        i_dest_value <= it.dest_value;
        i_src_value <= it.src_value;
        i_carry_in <= it.carry_in;
        i_ptr_first <= it.ptr_first;
        i_ptr_second <= it.ptr_second;
        i_sample_first <= it.sample_first;
        i_sample_second <= it.sample_second;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(execute_model(it));
        items_sent++;
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        out_stall_pct = stall_pct;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Output side: random stall, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // Compare every output transfer with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: result transfer with nothing expected", $time);
            end else begin
                want = pending_results.pop_front();
                check_field("reg_result", 64'(o_reg_result), 64'(want.reg_result));
                check_field("write_target", 64'(o_write_target), 64'(want.write_target));
                check_field("ptr_first_next", 64'(o_ptr_first_next),
                            64'(want.ptr_first_next));
                check_field("ptr_second_next", 64'(o_ptr_second_next),
                            64'(want.ptr_second_next));
                check_field("advance_pc", 64'(o_advance_pc), 64'(want.advance_pc));
                check_field("flag_n", 64'(o_flag_n), 64'(want.flag_n));
                check_field("flag_z", 64'(o_flag_z), 64'(want.flag_z));
                check_field("flag_v", 64'(o_flag_v), 64'(want.flag_v));
                check_field("flag_c", 64'(o_flag_c), 64'(want.flag_c));
                check_field("acc_high", 64'(o_acc_high), 64'(want.acc_high));
                check_field("acc_low", 64'(o_acc_low), 64'(want.acc_low));
                check_field("mac_overflow", 64'(o_mac_overflow), 64'(want.mac_overflow));
            end
        end
    end

    // Carry, borrow, overflow and zero corners of adc / sbc
    task automatic test_arith_flags();
        send_item(op_item(CMD_ADC, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1));
        send_item(op_item(CMD_ADC, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0));
        send_item(op_item(CMD_ADC, 32'h8000_0000, 32'h8000_0000, 1'b0));
        send_item(op_item(CMD_SBC, 32'h0000_0000, 32'h0000_0000, 1'b1));
        send_item(op_item(CMD_SBC, 32'h8000_0000, 32'h0000_0001, 1'b0));
        send_item(op_item(CMD_SBC, 32'h0000_0005, 32'h0000_0005, 1'b0));
        send_item(op_item(CMD_SBC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    endtask

    // Byte and halfword extension with junk in the upper bits
    task automatic test_extend();
        send_item(op_item(CMD_LD_B, 32'h1234_5678, 32'h5A5A_5A80, 1'b0));
        send_item(op_item(CMD_LD_UB, 32'h0, 32'hFFFF_FF80, 1'b1));
        send_item(op_item(CMD_LD_H, 32'h0, 32'h1234_8000, 1'b0));
        send_item(op_item(CMD_LD_UH, 32'h0, 32'hFFFF_8000, 1'b1));
    endtask

    task automatic test_multiply();
        send_item(op_item(CMD_MLT_W, 32'h8000_0000, 32'h8000_0000, 1'b0));
        send_item(op_item(CMD_MLT_H, 32'hFFFF_8000, 32'h0000_8000, 1'b0));
        send_item(op_item(CMD_MLTU_H, 32'h1234_FFFF, 32'h0000_FFFF, 1'b0));
        send_item(op_item(CMD_MLT_W, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0));
        send_item(op_item(CMD_MLTU_W, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    endtask

    // Pointer wrap, largest count, last step, the loop exit and the spare codes
    task automatic test_mac_stream();
        send_item(mac_item(32'hFFFF_FFFF, 32'h0000_1000, 32'h0000_2000, 16'h8000, 16'h7FFF));
        send_item(mac_item(32'h0000_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF));
        send_item(mac_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 16'h8000, 16'h8000));
        send_item(op_item(CMD_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send_item(op_item(CMD_SPARE_HI, 32'h0, 32'h0, 1'b0));
    endtask

    // A well-formed mac loop: count runs down to zero, pointers are fed back
    task automatic send_mac_loop();
        t_item       it;
        logic [31:0] p1;
        logic [31:0] p2;
        int          count;
        count = $urandom_range(6, 1);
        p1 = pick_word();
        p2 = pick_word();
        if ($urandom_range(1))
            send_item(rand_item(4'(CMD_MLT_H + $urandom_range(3))));
        for (int k = count; k >= 0; k--) begin
            it = mac_item(k, p1, p2, pick_sample(), pick_sample());
            send_item(it);
            p1 = p1 + PTR_STEP;
            p2 = p2 + PTR_STEP;
        end
    endtask

    task automatic test_random_traffic(input int n);
        int target;
        target = items_sent + n;
        while (items_sent < target) begin
            if ($urandom_range(99) < 45)
                send_mac_loop();
            else
                send_item(rand_item(4'($urandom_range(15))));
        end
    endtask

    // Output held off for a long stretch while input keeps coming
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_cycles = 80;
        repeat (40) send_item(rand_item(4'($urandom_range(CMD_MAC))));
    endtask

    // Run last: the sticky flag cannot be cleared without a reset
    task automatic test_mac_overflow();
        set_idling(20, 20);
        send_item(op_item(CMD_MLTU_W, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0));
        send_item(mac_item(32'd4, 32'h100, 32'h200, 16'h8000, 16'h8000));
        send_item(mac_item(32'd3, 32'h102, 32'h202, 16'h7FFF, 16'h7FFF));
        send_item(mac_item(32'd2, 32'h104, 32'h204, 16'h8000, 16'h8000));
        send_item(mac_item(32'd1, 32'h106, 32'h206, 16'h8000, 16'h7FFF));
        send_item(mac_item(32'd0, 32'h108, 32'h208, 16'h1234, 16'h4321));
        send_item(op_item(CMD_MLT_W, 32'h0000_0003, 32'hFFFF_FFFE, 1'b0));
        send_item(mac_item(32'd9, 32'h0, 32'h0, 16'h0001, 16'h0001));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(0, 0);
        test_arith_flags();
        test_extend();
        test_multiply();
        test_mac_stream();

        set_idling(0, 0);
        test_random_traffic(95);
        set_idling(48, 0);
        test_random_traffic(95);
        set_idling(0, 48);
        test_random_traffic(95);
        set_idling(20, 20);
        test_random_traffic(95);

        test_backpressure();
        test_mac_overflow();

        // drain
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0)
            $display("cpu_multiply_extend_execute_core regression: pass");
        else
            $display("cpu_multiply_extend_execute_core regression: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("cpu_multiply_extend_execute_core regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
sv/mxe_pkg.sv
sv/mxe_prep.sv
sv/mxe_accum.sv
sv/cpu_multiply_extend_execute_core.sv
sv/mxe_checker.sv
dv/tb.sv
